[src/assert_macros.svh]
// Assertion macros for the RTL of the head drive.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, switched off while reset is held.
`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

[src/qpd_pkg.sv]
// Package of the head drive: widths, register indexes, reset values and the gain bundle.
`timescale 1ns / 1ps
`default_nettype none

package qpd_pkg;

    // Default width of the tracked head positions.
    localparam int QPD_POS_BITS = 16;

    // Fixed field widths.
    localparam int TARGET_BITS = 16;
    localparam int POWER_BITS  = 8;
    localparam int MAG_BITS    = 7;
    localparam int GAIN_BITS   = 8;
    localparam int COUNT_BITS  = 8;

    // Configuration port.
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 8;

    localparam logic [CFG_ADDR_BITS-1:0] REG_KP_GAIN     = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_KD_GAIN     = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_POWER   = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MIN_POWER   = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_STILL_LIMIT = 3'd4;

    // Register values after reset.
    localparam logic [GAIN_BITS-1:0]  KP_GAIN_RST     = 8'd86;
    localparam logic [GAIN_BITS-1:0]  KD_GAIN_RST     = 8'd218;
    localparam logic [MAG_BITS-1:0]   MAX_POWER_RST   = 7'd127;
    localparam logic [MAG_BITS-1:0]   MIN_POWER_RST   = 7'd18;
    localparam logic [COUNT_BITS-1:0] STILL_LIMIT_RST = 8'd100;

    // Gains and power limits used by the per-axis power law.
    typedef struct packed {
        logic [GAIN_BITS-1:0] kp;
        logic [GAIN_BITS-1:0] kd;
        logic [MAG_BITS-1:0]  max_pwr;
        logic [MAG_BITS-1:0]  min_pwr;
    } qpd_cfg_t;

endpackage

`default_nettype wire

[src/qpd_power.sv]
// Per-axis PD power law: Q8 proportional minus damping term, then saturation to a motor power.
`timescale 1ns / 1ps
`default_nettype none

module qpd_power
    import qpd_pkg::*;
#(
    parameter int DELTA_BITS = QPD_POS_BITS + 1
) (
    input  wire logic signed [DELTA_BITS-1:0] delta,
    input  wire logic signed [DELTA_BITS-1:0] prev_delta,
    input  wire qpd_cfg_t                     cfg,
    output logic signed [POWER_BITS-1:0]      power
);

    localparam int DD_BITS   = DELTA_BITS + 1;
    localparam int PROD_BITS = DELTA_BITS + GAIN_BITS + 1;
    localparam int N_BITS    = PROD_BITS + 1;

    logic signed [DD_BITS-1:0]   dd;
    logic        [DD_BITS-1:0]   dd_abs;
    logic signed [PROD_BITS-1:0] prod_p;
    logic        [PROD_BITS-1:0] prod_d;
    logic signed [N_BITS-1:0]    n_val;
    logic        [N_BITS-1:0]    m_val;
    logic        [N_BITS-1:0]    max_q8;
    logic        [N_BITS-1:0]    min_q8;
    logic        [MAG_BITS-1:0]  mag;

    // Change of the error since the last tick, and its magnitude.
    always_comb begin
        dd     = DD_BITS'(delta) - DD_BITS'(prev_delta);
        dd_abs = dd[DD_BITS-1] ? DD_BITS'(-dd) : DD_BITS'(dd);
    end

    // Proportional and damping products, one multiplier each.
    always_comb begin
        prod_p = PROD_BITS'(delta) * PROD_BITS'($signed({1'b0, cfg.kp}));
        prod_d = PROD_BITS'(dd_abs) * PROD_BITS'(cfg.kd);
        n_val  = N_BITS'(prod_p) - $signed({1'b0, prod_d});
        m_val  = n_val[N_BITS-1] ? N_BITS'(-n_val) : N_BITS'(n_val);
    end

    // Saturation in Q8: cap first, then raise small nonzero values to the minimum.
    always_comb begin
        max_q8 = N_BITS'({cfg.max_pwr, 8'h00});
        min_q8 = N_BITS'({cfg.min_pwr, 8'h00});
        if (m_val > max_q8) begin
            mag = cfg.max_pwr;
        end else if ((n_val != '0) && (m_val < min_q8)) begin
            mag = cfg.min_pwr;
        end else begin
            mag = m_val[MAG_BITS+7:8];
        end
        power = n_val[N_BITS-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

endmodule

`default_nettype wire

[src/quadrature_pd_axis_drive.sv]
// Top level of the two-axis head drive: quadrature tracking, PD power and arrival detection.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Usage
// The slave channel takes one beat per item. s_tuser is the kind: 0 for an
// encoder sample (phases in s_tdata[3:0]), 1 for a control tick (targets in
// s_tdata[35:4]). Every beat yields exactly one beat on the master channel,
// carrying the powers, the arrival flag and the tracked positions; m_tuser
// is 1 when the powers come from a control tick.
// A result passes through both registers: the beat sits in the input
// register, then the position update, both products and the saturation are
// done in one pass into the output register, which drives m_tvalid.
// Throughput is one beat per cycle while the receiver does not stall; the
// state written by one beat is seen by the next.
// When the receiver stalls, the result waits in the output register and one
// further beat is still taken into the input register; after that s_tready
// falls until m_tready returns. Reset (aresetn low, synchronous) empties both
// registers, zeroes positions, phases, deltas and the stillness count, and
// restores the register defaults. The user must see that registers are
// written over the cfg port only while no beat is in flight; the block does not enforce it.
module quadrature_pd_axis_drive
    import qpd_pkg::*;
#(
    parameter int POS_BITS = QPD_POS_BITS
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // Configuration writes
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
    // Input stream
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // [3:0] encoder_bits, [19:4] target_x, [35:20] target_y, [39:36] zero
    input  wire logic [39:0]              s_tdata,
    // [0] kind
    input  wire logic                     s_tuser,
    // Result stream
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // [7:0] power_x, [15:8] power_y, [16] arrived, [32:17] position_x,
    // [48:33] position_y, [55:49] zero
    output logic [55:0]                   m_tdata,
    // [0] drive_valid
    output logic                          m_tuser
);

    localparam int DELTA_BITS = ((POS_BITS > TARGET_BITS) ? POS_BITS : TARGET_BITS) + 1;

    // Quadrature phase codes in the forward order 10, 11, 01, 00.
    localparam logic [1:0] PH_10 = 2'b10;
    localparam logic [1:0] PH_11 = 2'b11;
    localparam logic [1:0] PH_01 = 2'b01;
    localparam logic [1:0] PH_00 = 2'b00;

    // Configuration registers.
    logic [GAIN_BITS-1:0]  kp_gain_reg;
    logic [GAIN_BITS-1:0]  kd_gain_reg;
    logic [MAG_BITS-1:0]   max_power_reg;
    logic [MAG_BITS-1:0]   min_power_reg;
    logic [COUNT_BITS-1:0] still_limit_reg;
    qpd_cfg_t              pwr_cfg;

    // Input register.
    logic                          in_valid_reg;
    logic                          in_valid_next;
    logic                          in_kind_reg;
    logic [3:0]                    in_enc_reg;
    logic signed [TARGET_BITS-1:0] in_tgt_x_reg;
    logic signed [TARGET_BITS-1:0] in_tgt_y_reg;

    // Tracking state.
    logic [POS_BITS-1:0]          head_x_reg, head_x_next;
    logic [POS_BITS-1:0]          head_y_reg, head_y_next;
    logic [1:0]                   phase_x_reg, phase_x_next;
    logic [1:0]                   phase_y_reg, phase_y_next;
    logic                         phase_seen_reg, phase_seen_next;
    logic signed [DELTA_BITS-1:0] prev_dx_reg, prev_dx_next;
    logic signed [DELTA_BITS-1:0] prev_dy_reg, prev_dy_next;
    logic [COUNT_BITS-1:0]        still_cnt_reg, still_cnt_next;

    // Output register.
    logic                  m_valid_reg, m_valid_next;
    logic                  out_drive_reg;
    logic [POWER_BITS-1:0] out_pwr_x_reg;
    logic [POWER_BITS-1:0] out_pwr_y_reg;
    logic                  out_arrived_reg;
    logic [15:0]           out_pos_x_reg;
    logic [15:0]           out_pos_y_reg;

    // Datapath.
    logic                         s_accept;
    logic                         advance;
    logic                         out_load;
    logic signed [DELTA_BITS-1:0] dx;
    logic signed [DELTA_BITS-1:0] dy;
    logic signed [POWER_BITS-1:0] raw_pwr_x;
    logic signed [POWER_BITS-1:0] raw_pwr_y;
    logic [COUNT_BITS-1:0]        cnt_step;
    logic                         still_over;
    logic                         at_target;
    logic [POWER_BITS-1:0]        res_pwr_x;
    logic [POWER_BITS-1:0]        res_pwr_y;
    logic                         res_arrived;

    // Forward step (decrement): the next code in the order 10, 11, 01, 00.
    function automatic logic is_forward(input logic [1:0] old_ph, input logic [1:0] cur_ph);
        return ((old_ph == PH_10) && (cur_ph == PH_11)) ||
               ((old_ph == PH_11) && (cur_ph == PH_01)) ||
               ((old_ph == PH_01) && (cur_ph == PH_00)) ||
               ((old_ph == PH_00) && (cur_ph == PH_10));
    endfunction

    // New position of one axis after an encoder sample.
    function automatic logic [POS_BITS-1:0] track(input logic [POS_BITS-1:0] head,
                                                  input logic [1:0] old_ph,
                                                  input logic [1:0] cur_ph,
                                                  input logic seen);
        logic [POS_BITS-1:0] res;
        if (seen && (old_ph == cur_ph)) begin
            res = head;
        end else if (seen && is_forward(old_ph, cur_ph)) begin
            res = head - POS_BITS'(1);
        end else begin
            res = head + POS_BITS'(1);
        end
        return res;
    endfunction

    // Handshake: the input register drains whenever the output register can take a result.
    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign out_load = in_valid_reg && advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_gain_reg     <= KP_GAIN_RST;
            kd_gain_reg     <= KD_GAIN_RST;
            max_power_reg   <= MAX_POWER_RST;
            min_power_reg   <= MIN_POWER_RST;
            still_limit_reg <= STILL_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_KP_GAIN:     kp_gain_reg     <= cfg_wdata;
                REG_KD_GAIN:     kd_gain_reg     <= cfg_wdata;
                REG_MAX_POWER:   max_power_reg   <= cfg_wdata[MAG_BITS-1:0];
                REG_MIN_POWER:   min_power_reg   <= cfg_wdata[MAG_BITS-1:0];
                REG_STILL_LIMIT: still_limit_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign pwr_cfg = '{kp: kp_gain_reg, kd: kd_gain_reg,
                       max_pwr: max_power_reg, min_pwr: min_power_reg};

    // Errors against the target, both sides sign-extended.
    always_comb begin
        dx = DELTA_BITS'(in_tgt_x_reg) - DELTA_BITS'($signed(head_x_reg));
        dy = DELTA_BITS'(in_tgt_y_reg) - DELTA_BITS'($signed(head_y_reg));
    end

    qpd_power #(
        .DELTA_BITS (DELTA_BITS)
    ) u_power_x (
        .delta      (dx),
        .prev_delta (prev_dx_reg),
        .cfg        (pwr_cfg),
        .power      (raw_pwr_x)
    );

    qpd_power #(
        .DELTA_BITS (DELTA_BITS)
    ) u_power_y (
        .delta      (dy),
        .prev_delta (prev_dy_reg),
        .cfg        (pwr_cfg),
        .power      (raw_pwr_y)
    );

    // Stillness count, arrival and the retry drive when stuck away from the target.
    always_comb begin
        if ((raw_pwr_x == '0) && (raw_pwr_y == '0)) begin
            cnt_step = (still_cnt_reg == '1) ? still_cnt_reg : still_cnt_reg + COUNT_BITS'(1);
        end else begin
            cnt_step = '0;
        end
        still_over = cnt_step > still_limit_reg;
        at_target  = (dx == '0) && (dy == '0);
    end

    // Next state and result for the beat held in the input register.
    always_comb begin
        head_x_next     = head_x_reg;
        head_y_next     = head_y_reg;
        phase_x_next    = phase_x_reg;
        phase_y_next    = phase_y_reg;
        phase_seen_next = phase_seen_reg;
        prev_dx_next    = prev_dx_reg;
        prev_dy_next    = prev_dy_reg;
        still_cnt_next  = still_cnt_reg;
        res_pwr_x       = '0;
        res_pwr_y       = '0;
        res_arrived     = 1'b0;
        if (!in_kind_reg) begin
            head_x_next     = track(head_x_reg, phase_x_reg, in_enc_reg[1:0], phase_seen_reg);
            head_y_next     = track(head_y_reg, phase_y_reg, in_enc_reg[3:2], phase_seen_reg);
            phase_x_next    = in_enc_reg[1:0];
            phase_y_next    = in_enc_reg[3:2];
            phase_seen_next = 1'b1;
        end else begin
            prev_dx_next   = dx;
            prev_dy_next   = dy;
            still_cnt_next = cnt_step;
            res_pwr_x      = raw_pwr_x;
            res_pwr_y      = raw_pwr_y;
            if (still_over && at_target) begin
                res_arrived    = 1'b1;
                still_cnt_next = '0;
            end else if (still_over) begin
                res_pwr_x = {1'b0, max_power_reg};
                res_pwr_y = {1'b0, max_power_reg};
            end
        end
    end

    // Control and tracking state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            head_x_reg     <= '0;
            head_y_reg     <= '0;
            phase_x_reg    <= '0;
            phase_y_reg    <= '0;
            phase_seen_reg <= 1'b0;
            prev_dx_reg    <= '0;
            prev_dy_reg    <= '0;
            still_cnt_reg  <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (out_load) begin
                head_x_reg     <= head_x_next;
                head_y_reg     <= head_y_next;
                phase_x_reg    <= phase_x_next;
                phase_y_reg    <= phase_y_next;
                phase_seen_reg <= phase_seen_next;
                prev_dx_reg    <= prev_dx_next;
                prev_dy_reg    <= prev_dy_next;
                still_cnt_reg  <= still_cnt_next;
            end
        end
    end

    // Payload registers of both stages.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_kind_reg  <= s_tuser;
            in_enc_reg   <= s_tdata[3:0];
            in_tgt_x_reg <= s_tdata[19:4];
            in_tgt_y_reg <= s_tdata[35:20];
        end
        if (out_load) begin
            out_drive_reg   <= in_kind_reg;
            out_pwr_x_reg   <= res_pwr_x;
            out_pwr_y_reg   <= res_pwr_y;
            out_arrived_reg <= res_arrived;
            out_pos_x_reg   <= 16'(head_x_next);
            out_pos_y_reg   <= 16'(head_y_next);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_drive_reg;
    assign m_tdata  = {7'd0, out_pos_y_reg, out_pos_x_reg, out_arrived_reg,
                       out_pwr_y_reg, out_pwr_x_reg};

    // Encoder-sample results carry no power and no arrival.
    `ASSERT_IMP(a_sample_quiet, aclk, aresetn, m_tvalid && !m_tuser, m_tdata[16:0] == '0)
    // An arrival restarts the stillness count.
    `ASSERT_NEXT(a_arrive_clears, aclk, aresetn, out_load && res_arrived, still_cnt_reg == '0)
    // A waiting result is not overwritten while the input register still holds a beat.
    `ASSERT_NEXT(a_hold_pending, aclk, aresetn, m_tvalid && !m_tready && in_valid_reg,
                 in_valid_reg && m_tvalid)

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the two-axis quadrature PD head drive.
`timescale 1ns / 1ps

module testbench;
    import qpd_pkg::*;

    // Kind of an input beat, carried on s_tuser.
    localparam bit KIND_ENCODER = 1'b0;
    localparam bit KIND_TICK    = 1'b1;

    // Receiver hold-off that is long enough to back the block up.
    localparam int BURST_CYCLES = 60;
    // Cycles allowed after the last result for anything stray to show up.
    localparam int TAIL_CYCLES  = 10;

    typedef struct packed {
        bit                 kind;
        logic [3:0]         enc;
        logic signed [15:0] tgt_x;
        logic signed [15:0] tgt_y;
    } head_item_t;

    typedef struct packed {
        logic               drive;
        logic signed [7:0]  pwr_x;
        logic signed [7:0]  pwr_y;
        logic               arrived;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
    } drive_result_t;

    typedef struct {
        head_item_t    item;
        bit            typed;
        drive_result_t want;
    } drive_row_t;

    typedef struct {
        int kp;
        int kd;
        int maxp;
        int minp;
        int lim;
        int count;
        int tick_pct;
        bit calm;
        bit burst;
    } drive_phase_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        m_tuser;

    quadrature_pd_axis_drive dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Model state of the drive, kept in step with accepted beats.
    logic signed [15:0] head_x = '0;
    logic signed [15:0] head_y = '0;
    logic [1:0]         phase_x = '0;
    logic [1:0]         phase_y = '0;
    bit                 phase_seen = 1'b0;
    longint             prev_dx = 0;
    longint             prev_dy = 0;
    int                 still_count = 0;
    int                 kp_now  = KP_GAIN_RST;
    int                 kd_now  = KD_GAIN_RST;
    int                 max_now = MAX_POWER_RST;
    int                 min_now = MIN_POWER_RST;
    int                 lim_now = STILL_LIMIT_RST;

    drive_result_t drive_queue[$];
    drive_row_t    directed_rows[$];
    int            fault_count = 0;
    bit            calm_run = 1'b0;
    bit            burst_hold = 1'b0;
    drive_result_t got_res;
    drive_result_t want_res;

    // Next phase in the forward order, which counts the position down.
    function automatic logic [1:0] fwd_next(input logic [1:0] p);
        case (p)
            2'b10:   return 2'b11;
            2'b11:   return 2'b01;
            2'b01:   return 2'b00;
            default: return 2'b10;
        endcase
    endfunction

    function automatic logic [1:0] bwd_next(input logic [1:0] p);
        case (p)
            2'b11:   return 2'b10;
            2'b01:   return 2'b11;
            2'b00:   return 2'b01;
            default: return 2'b00;
        endcase
    endfunction

    function automatic logic signed [15:0] step_axis(input logic signed [15:0] pos,
                                                     input logic [1:0] old,
                                                     input logic [1:0] cur);
        if (phase_seen && old == cur) return pos;
        if (phase_seen && cur == fwd_next(old)) return pos - 16'sd1;
        return pos + 16'sd1;
    endfunction

    // PD law in Q8, saturated on the exact value and then truncated toward zero.
    function automatic logic signed [7:0] axis_power(input longint delta, input longint prev);
        longint dd;
        longint n;
        longint m;
        longint mag;
        dd = delta - prev;
        if (dd < 0) dd = -dd;
        n = delta * kp_now - dd * kd_now;
        m = (n < 0) ? -n : n;
        if (m > longint'(max_now) * 256) mag = max_now;
        else if (n != 0 && m < longint'(min_now) * 256) mag = min_now;
        else mag = m / 256;
        return 8'((n < 0) ? -mag : mag);
    endfunction

    function automatic drive_result_t predict_drive(input head_item_t it);
        drive_result_t res;
        longint dx;
        longint dy;
        res = '0;
        if (it.kind == KIND_ENCODER) begin
            head_x = step_axis(head_x, phase_x, it.enc[1:0]);
            head_y = step_axis(head_y, phase_y, it.enc[3:2]);
            phase_x = it.enc[1:0];
            phase_y = it.enc[3:2];
            phase_seen = 1'b1;
        end else begin
            dx = longint'(it.tgt_x) - longint'(head_x);
            dy = longint'(it.tgt_y) - longint'(head_y);
            res.drive = 1'b1;
            res.pwr_x = axis_power(dx, prev_dx);
            res.pwr_y = axis_power(dy, prev_dy);
            if (res.pwr_x == 0 && res.pwr_y == 0) begin
                if (still_count < 255) still_count++;
            end else begin
                still_count = 0;
            end
            // Long stillness: either arrival at the target or a full-power retry.
            if (still_count > lim_now) begin
                if (dx == 0 && dy == 0) begin
                    res.arrived = 1'b1;
                    still_count = 0;
                end else begin
                    res.pwr_x = 8'(max_now);
                    res.pwr_y = 8'(max_now);
                end
            end
            prev_dx = dx;
            prev_dy = dy;
        end
        res.pos_x = head_x;
        res.pos_y = head_y;
        return res;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 6);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [1:0] wander(input logic [1:0] p);
        case ($urandom_range(0, 2))
            0:       return p;
            1:       return fwd_next(p);
            default: return bwd_next(p);
        endcase
    endfunction

    // Random beat, mostly legal phase steps and targets near the tracked head.
    function automatic head_item_t make_item(input int tick_pct);
        head_item_t it;
        int         s;
        it.enc   = 4'($urandom);
        it.tgt_x = 16'($urandom);
        it.tgt_y = 16'($urandom);
        s = $urandom_range(0, 9);
        if ($urandom_range(0, 99) < tick_pct) begin
            it.kind = KIND_TICK;
            if (s < 4) begin
                it.tgt_x = head_x;
                it.tgt_y = head_y;
            end else if (s < 8) begin
                it.tgt_x = head_x + 16'($urandom_range(0, 6)) - 16'sd3;
                it.tgt_y = head_y + 16'($urandom_range(0, 6)) - 16'sd3;
            end
        end else begin
            it.kind = KIND_ENCODER;
            if (s < 8) it.enc = {wander(phase_y), wander(phase_x)};
        end
        return it;
    endfunction

    task automatic add_row(input bit kind, input logic [3:0] enc, input int tx, input int ty,
                           input bit typed, input int px, input int py, input bit arr,
                           input int posx, input int posy);
        drive_row_t row;
        row.item  = '{kind: kind, enc: enc, tgt_x: 16'(tx), tgt_y: 16'(ty)};
        row.typed = typed;
        row.want  = '{drive: kind, pwr_x: 8'(px), pwr_y: 8'(py), arrived: arr,
                      pos_x: 16'(posx), pos_y: 16'(posy)};
        directed_rows.push_back(row);
    endtask

    // Offer one beat and book its expected result once it is taken.
    task automatic send_item(input head_item_t it, input bit typed, input drive_result_t want);
        int            gap;
        drive_result_t predicted;
        gap = calm_run ? 0 : idle_span();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {4'b0, it.tgt_y, it.tgt_x, it.enc};
        do @(posedge aclk); while (!s_tready);
        predicted = predict_drive(it);
        drive_queue.push_back(typed ? want : predicted);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (drive_queue.size() != 0) @(posedge aclk);
    endtask

    // Write every register, with the block idle.
    task automatic load_settings(input drive_phase_t ph);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_KP_GAIN;
        cfg_wdata <= 8'(ph.kp);
        @(negedge aclk);
        cfg_addr  <= REG_KD_GAIN;
        cfg_wdata <= 8'(ph.kd);
        @(negedge aclk);
        cfg_addr  <= REG_MAX_POWER;
        cfg_wdata <= 8'(ph.maxp);
        @(negedge aclk);
        cfg_addr  <= REG_MIN_POWER;
        cfg_wdata <= 8'(ph.minp);
        @(negedge aclk);
        cfg_addr  <= REG_STILL_LIMIT;
        cfg_wdata <= 8'(ph.lim);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        kp_now  = ph.kp;
        kd_now  = ph.kd;
        max_now = ph.maxp;
        min_now = ph.minp;
        lim_now = ph.lim;
    endtask

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
            fault_count++;
        end
    endtask

    // Result side: compare each beat with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_res = '{drive: m_tuser, pwr_x: m_tdata[7:0], pwr_y: m_tdata[15:8],
                        arrived: m_tdata[16], pos_x: m_tdata[32:17], pos_y: m_tdata[48:33]};
            if (drive_queue.size() == 0) begin
                $display("%0t: result beat with nothing expected, got %h", $time, m_tdata);
                fault_count++;
            end else begin
                want_res = drive_queue.pop_front();
                check_field("drive_valid", want_res.drive, got_res.drive);
                check_field("power_x", want_res.pwr_x, got_res.pwr_x);
                check_field("power_y", want_res.pwr_y, got_res.pwr_y);
                check_field("arrived", want_res.arrived, got_res.arrived);
                check_field("position_x", want_res.pos_x, got_res.pos_x);
                check_field("position_y", want_res.pos_y, got_res.pos_y);
            end
        end
    end

    // Receiver: random stalls, free running in calm phases, one long hold-off on request.
    initial begin
        int stall;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (burst_hold) begin
                m_tready <= 1'b0;
                repeat (BURST_CYCLES) @(negedge aclk);
                burst_hold = 1'b0;
            end else begin
                stall = calm_run ? 0 : idle_span();
                if (stall == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    repeat (stall - 1) @(negedge aclk);
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("quadrature_pd_axis_drive verification failed");
        $finish;
    end

    // Stimulus: directed rows at reset settings, then phases of random beats.
    initial begin
        drive_phase_t  phases[7];
        drive_result_t none;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tuser   = 1'b0;
        s_tdata   = '0;
        none      = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Phase tracking: first sample, no change, forward order, backward, jumps.
        add_row(KIND_ENCODER, 4'b0000, 0, 0, 1, 0, 0, 0, 1, 1);
        add_row(KIND_ENCODER, 4'b0000, 0, 0, 1, 0, 0, 0, 1, 1);
        add_row(KIND_ENCODER, 4'b0010, 0, 0, 1, 0, 0, 0, 0, 1);
        add_row(KIND_ENCODER, 4'b0011, 0, 0, 1, 0, 0, 0, -1, 1);
        add_row(KIND_ENCODER, 4'b1001, 0, 0, 1, 0, 0, 0, -2, 0);
        add_row(KIND_ENCODER, 4'b1100, 0, 0, 1, 0, 0, 0, -3, -1);
        add_row(KIND_ENCODER, 4'b1001, 0, 0, 1, 0, 0, 0, -2, 0);
        add_row(KIND_ENCODER, 4'b0110, 0, 0, 1, 0, 0, 0, -1, 1);
        add_row(KIND_ENCODER, 4'b1111, 0, 0, 1, 0, 0, 0, -2, 2);
        // Power law: at target, extreme targets, min raise, truncation of a negative value.
        add_row(KIND_TICK, 4'b0000, -2, 2, 1, 0, 0, 0, -2, 2);
        add_row(KIND_TICK, 4'b0000, 32767, -32768, 1, -127, -127, 0, -2, 2);
        add_row(KIND_TICK, 4'b0000, -32768, 32767, 1, -127, -127, 0, -2, 2);
        add_row(KIND_TICK, 4'b0000, -2, 2, 1, -127, -127, 0, -2, 2);
        add_row(KIND_TICK, 4'b0000, -1, 2, 1, -18, 0, 0, -2, 2);
        add_row(KIND_TICK, 4'b0000, -1, 2, 1, 18, 0, 0, -2, 2);
        add_row(KIND_TICK, 4'b0000, 58, 2, 1, -30, 0, 0, -2, 2);
        add_row(KIND_TICK, 4'b0000, 108, -40, 0, 0, 0, 0, 0, 0);
        add_row(KIND_ENCODER, 4'b0101, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(KIND_TICK, 4'b0000, -300, 700, 0, 0, 0, 0, 0, 0);
        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        drain();

        // Gain extremes with immediate arrival; min above max; a still counter that saturates.
        phases[0] = '{255, 0, 127, 0, 0, 70, 50, 1'b1, 1'b1};
        phases[1] = '{0, 255, 1, 127, 254, 60, 50, 1'b0, 1'b0};
        phases[2] = '{0, 0, 127, 18, 254, 300, 90, 1'b1, 1'b0};
        phases[3] = '{86, 218, 127, 18, 100, 80, 50, 1'b0, 1'b0};
        for (int p = 4; p < 7; p++) begin
            phases[p] = '{$urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(1, 127), $urandom_range(0, 127),
                          $urandom_range(0, 12), 50, 60, 1'b0, 1'b0};
        end
        foreach (phases[p]) begin
            load_settings(phases[p]);
            calm_run   = phases[p].calm;
            burst_hold = phases[p].burst;
            repeat (phases[p].count) send_item(make_item(phases[p].tick_pct), 1'b0, none);
            drain();
        end
        calm_run = 1'b0;

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fault_count == 0) begin
            $display("quadrature_pd_axis_drive verification clean");
        end else begin
            $display("quadrature_pd_axis_drive verification failed");
        end
        $finish;
    end

endmodule
